[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spq port check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spq port check failed");

`endif

[hw/rtl/spq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam logic [2:0] CMD_INSERT  = 3'd0;
   localparam logic [2:0] CMD_POP     = 3'd1;
   localparam logic [2:0] CMD_UPGRADE = 3'd2;
   localparam logic [2:0] CMD_CLEAR   = 3'd3;
   localparam logic [2:0] CMD_PEEK    = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_REFUSED   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] entry_tag;
      logic [15:0] entry_priority;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] popped_tag;
      logic [15:0] front_tag;
      logic [15:0] front_priority;
      logic        queue_empty;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP,
      CELL_UPGRADE
   } cell_op_type;

   typedef struct packed {
      logic        scan;
      cell_op_type op;
   } cell_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module spq_cell import spq_pkg::*; #(
   parameter int TAG_WIDTH      = 16,
   parameter int PRIORITY_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctl_type              ctl,
   input  logic [TAG_WIDTH-1:0]      key_tag,
   input  logic [PRIORITY_WIDTH-1:0] key_prio,
   input  logic                      occupied,
   input  logic [TAG_WIDTH-1:0]      left_tag,
   input  logic [PRIORITY_WIDTH-1:0] left_prio,
   input  logic                      left_le,
   input  logic [TAG_WIDTH-1:0]      right_tag,
   input  logic [PRIORITY_WIDTH-1:0] right_prio,
   input  logic                      seen_in,
   output logic [TAG_WIDTH-1:0]      cur_tag,
   output logic [PRIORITY_WIDTH-1:0] cur_prio,
   output logic                      le,
   output logic                      seen_out,
   output logic                      hit,
   output logic [TAG_WIDTH-1:0]      next_tag,
   output logic [PRIORITY_WIDTH-1:0] next_prio
);

   logic [TAG_WIDTH-1:0]      tag_ff, tag_in;
   logic [PRIORITY_WIDTH-1:0] prio_ff, prio_in;
   logic                      hit_ff, hit_in;
   logic                      match;
   logic                      chain;

   assign match = occupied && (tag_ff == key_tag);
   assign le    = occupied && (prio_ff <= key_prio);

   // scan cycle: chain carries tag matches; apply cycle: the latched first hit
   assign chain    = ctl.scan ? match : hit_ff;
   assign seen_out = seen_in | chain;
   assign hit_in   = ctl.scan ? (match & ~seen_in) : hit_ff;

   always_comb begin
      tag_in  = tag_ff;
      prio_in = prio_ff;
      case (ctl.op)
         CELL_INSERT, CELL_UPGRADE: begin
            // upgrade leaves everything behind the old entry in place
            if (!(ctl.op == CELL_UPGRADE && seen_in) && !le) begin
               if (left_le) begin
                  tag_in  = key_tag;
                  prio_in = key_prio;
               end else begin
                  tag_in  = left_tag;
                  prio_in = left_prio;
               end
            end
         end
         CELL_POP: begin
            tag_in  = right_tag;
            prio_in = right_prio;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      prio_ff <= prio_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign cur_tag   = tag_ff;
   assign cur_prio  = prio_ff;
   assign hit       = hit_ff;
   assign next_tag  = tag_in;
   assign next_prio = prio_in;

endmodule

`default_nettype wire

[hw/rtl/stable_priority_queue_with_upgrade.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                        direction  timing
// request   start, busy, req_word        in         taken when start && !busy
// response  rsp_strobe, rsp_word         out        one cycle wide, no back-pressure
//
// Every command runs as a scan cycle (tag match ripples down the cell chain)
// and an apply cycle (all cells shift or hold in parallel). The next command
// may be taken in the apply cycle.
// rsp_strobe rises in the cycle after the apply cycle.
// Synchronous reset empties the queue; slot contents are not cleared.
// The receiver cannot stall; busy is high only in the scan cycle.

module stable_priority_queue_with_upgrade import spq_pkg::*; #(
   parameter int CAPACITY       = 16,
   parameter int TAG_WIDTH      = 16,
   parameter int PRIORITY_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY
   } state_type;

   state_type                 state_ff, state_in;
   logic [2:0]                cmd_ff, cmd_in;
   logic [TAG_WIDTH-1:0]      key_tag_ff, key_tag_in;
   logic [PRIORITY_WIDTH-1:0] key_prio_ff, key_prio_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   rsp_type                   rsp_word_ff, rsp_word_in;

   cell_ctl_type              ctl;
   logic                      accept;
   logic                      full, empty, found;
   logic [PRIORITY_WIDTH-1:0] hit_prio;

   logic [TAG_WIDTH-1:0]      c_tag [CAPACITY];
   logic [PRIORITY_WIDTH-1:0] c_prio [CAPACITY];
   logic [TAG_WIDTH-1:0]      n_tag [CAPACITY];
   logic [PRIORITY_WIDTH-1:0] n_prio [CAPACITY];
   logic [CAPACITY-1:0]       occ, le, hit;
   logic [CAPACITY:0]         seen;

   logic [TAG_WIDTH+15:0]      req_tag_w, pop_tag_w, front_tag_w;
   logic [PRIORITY_WIDTH+15:0] req_prio_w, front_prio_w;
   logic [CW+4:0]              count_w;

   assign seen[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [TAG_WIDTH-1:0]      l_tag, r_tag;
      logic [PRIORITY_WIDTH-1:0] l_prio, r_prio;
      logic                      l_le;

      assign occ[i] = count_ff > CW'(i);

      if (i == 0) begin : g_head
         assign l_tag  = '0;
         assign l_prio = '0;
         assign l_le   = 1'b1;
      end else begin : g_body
         assign l_tag  = c_tag[i-1];
         assign l_prio = c_prio[i-1];
         assign l_le   = le[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign r_tag  = '0;
         assign r_prio = '0;
      end else begin : g_next
         assign r_tag  = c_tag[i+1];
         assign r_prio = c_prio[i+1];
      end

      spq_cell #(
         .TAG_WIDTH      (TAG_WIDTH),
         .PRIORITY_WIDTH (PRIORITY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key_tag    (key_tag_ff),
         .key_prio   (key_prio_ff),
         .occupied   (occ[i]),
         .left_tag   (l_tag),
         .left_prio  (l_prio),
         .left_le    (l_le),
         .right_tag  (r_tag),
         .right_prio (r_prio),
         .seen_in    (seen[i]),
         .cur_tag    (c_tag[i]),
         .cur_prio   (c_prio[i]),
         .le         (le[i]),
         .seen_out   (seen[i+1]),
         .hit        (hit[i]),
         .next_tag   (n_tag[i]),
         .next_prio  (n_prio[i])
      );
   end

   // priority of the first tag match, cells hold a one-hot hit
   always_comb begin
      hit_prio = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_prio = hit_prio | ({PRIORITY_WIDTH{hit[i]}} & c_prio[i]);
      end
   end

   assign accept = start && !busy;
   assign full   = count_ff == CW'(CAPACITY);
   assign empty  = count_ff == '0;
   assign found  = |hit;

   always_comb begin
      ctl.scan = (state_ff == S_SCAN);
      ctl.op   = CELL_HOLD;
      if (state_ff == S_APPLY) begin
         case (cmd_ff)
            CMD_INSERT:  ctl.op = full  ? CELL_HOLD : CELL_INSERT;
            CMD_POP:     ctl.op = empty ? CELL_HOLD : CELL_POP;
            CMD_UPGRADE: ctl.op = (found && hit_prio > key_prio_ff) ? CELL_UPGRADE : CELL_HOLD;
            default:     ctl.op = CELL_HOLD;
         endcase
      end
   end

   always_comb begin
      req_tag_w   = {16'b0, req_word.entry_tag};
      req_prio_w  = {16'b0, req_word.entry_priority};
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      key_tag_in  = key_tag_ff;
      key_prio_in = key_prio_ff;
      count_in    = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;

      if (state_ff == S_APPLY) begin
         rsp_word_in.status = ST_OK;
         case (cmd_ff)
            CMD_INSERT: begin
               if (full) rsp_word_in.status = ST_FULL;
               else      count_in = count_ff + CW'(1);
            end
            CMD_POP: begin
               if (empty) rsp_word_in.status = ST_EMPTY;
               else       count_in = count_ff - CW'(1);
            end
            CMD_UPGRADE: begin
               if (!found)                      rsp_word_in.status = ST_NOT_FOUND;
               else if (hit_prio < key_prio_ff) rsp_word_in.status = ST_REFUSED;
            end
            CMD_CLEAR: count_in = '0;
            CMD_PEEK: begin
               if (empty) rsp_word_in.status = ST_EMPTY;
            end
            default: begin
            end
         endcase
         rsp_strobe_in = 1'b1;
         state_in      = S_IDLE;
      end else if (state_ff == S_SCAN) begin
         state_in = S_APPLY;
      end

      pop_tag_w    = {16'b0, ((ctl.op == CELL_POP) ? c_tag[0] : TAG_WIDTH'(0))};
      front_tag_w  = {16'b0, ((count_in != '0) ? n_tag[0] : TAG_WIDTH'(0))};
      front_prio_w = {16'b0, ((count_in != '0) ? n_prio[0] : PRIORITY_WIDTH'(0))};
      count_w      = {5'b0, count_in};
      if (state_ff == S_APPLY) begin
         rsp_word_in.popped_tag     = pop_tag_w[15:0];
         rsp_word_in.front_tag      = front_tag_w[15:0];
         rsp_word_in.front_priority = front_prio_w[15:0];
         rsp_word_in.queue_empty    = count_in == '0;
         rsp_word_in.entry_count    = count_w[4:0];
      end

      if (accept) begin
         cmd_in      = req_word.command;
         key_tag_in  = req_tag_w[TAG_WIDTH-1:0];
         key_prio_in = req_prio_w[PRIORITY_WIDTH-1:0];
         state_in    = S_SCAN;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_tag_ff  <= key_tag_in;
      key_prio_ff <= key_prio_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy       = (state_ff == S_SCAN);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

`default_nettype wire

[hw/rtl/spq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spq_checker import spq_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_word,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_word
);

   logic unused_req;
   assign unused_req = ^req_word;

   // an accepted word blocks the port for its scan cycle
   `SPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

   // every taken word is answered, its response strobe following the scan and apply cycles
   `SPQ_ASSERT_NOW(a_rsp_latency, start && !busy, ##3 rsp_strobe)

   // the response strobe is never high back to back
   `SPQ_ASSERT_NEXT(a_rsp_spacing, rsp_strobe, !rsp_strobe)

   // an empty queue shows no front entry
   `SPQ_ASSERT_NOW(a_empty_front, rsp_strobe && rsp_word.queue_empty,
      rsp_word.front_tag == 16'd0 && rsp_word.front_priority == 16'd0)

endmodule

bind stable_priority_queue_with_upgrade spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

`default_nettype wire

[test/tb_stable_priority_queue_with_upgrade.sv]
`timescale 1ns / 1ps

module tb_stable_priority_queue_with_upgrade;
   import spq_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 1050;

   // command codes the block treats as no-ops
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_UPGRADE,
      MIX_ANY
   } mix_type;

   typedef struct {
      req_type     word;
      int unsigned gap;
      bit          settle;
   } stim_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   stim_item_type stim_items[$];
   stim_item_type staged;
   bit            have_staged = 1'b0;
   int unsigned   gap_left = 0;
   int            stim_total = 0;
   int            words_sent = 0;
   int            replies_checked = 0;
   int            mismatches = 0;
   int            cycle_count = 0;
   int            status_hits[5] = '{default: 0};

   // shadow of the sorted queue
   logic [15:0] held_tags[CAPACITY];
   logic [15:0] held_prios[CAPACITY];
   int          held_count = 0;
   rsp_type     step_outcomes[$];

   stable_priority_queue_with_upgrade dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always #1 clock = ~clock;

   // new entry lands behind every entry with score <= its own
   function automatic void place_entry(logic [15:0] tag, logic [15:0] prio);
      int pos;
      pos = 0;
      while (pos < held_count && held_prios[pos] <= prio) pos++;
      for (int i = held_count; i > pos; i--) begin
         held_tags[i]  = held_tags[i - 1];
         held_prios[i] = held_prios[i - 1];
      end
      held_tags[pos]  = tag;
      held_prios[pos] = prio;
      held_count++;
   endfunction

   function automatic void drop_entry(int pos);
      for (int i = pos; i + 1 < held_count; i++) begin
         held_tags[i]  = held_tags[i + 1];
         held_prios[i] = held_prios[i + 1];
      end
      held_count--;
   endfunction

   function automatic rsp_type apply_command(req_type w);
      rsp_type r;
      int      hit;
      r = '0;
      r.status = ST_OK;
      hit = -1;
      case (w.command)
         CMD_INSERT: begin
            if (held_count >= CAPACITY) r.status = ST_FULL;
            else place_entry(w.entry_tag, w.entry_priority);
         end
         CMD_POP: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.popped_tag = held_tags[0];
               drop_entry(0);
            end
         end
         CMD_UPGRADE: begin
            for (int i = 0; i < held_count && hit < 0; i++)
               if (held_tags[i] == w.entry_tag) hit = i;
            if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else if (held_prios[hit] < w.entry_priority) begin
               r.status = ST_REFUSED;
            end else if (held_prios[hit] != w.entry_priority) begin
               drop_entry(hit);
               place_entry(w.entry_tag, w.entry_priority);
            end
         end
         CMD_CLEAR: held_count = 0;
         CMD_PEEK: if (held_count == 0) r.status = ST_EMPTY;
         default: ;
      endcase
      if (held_count > 0) begin
         r.front_tag      = held_tags[0];
         r.front_priority = held_prios[0];
      end
      r.queue_empty = (held_count == 0);
      r.entry_count = held_count[4:0];
      return r;
   endfunction

   task automatic queue_word(logic [2:0] cmd, logic [15:0] tag, logic [15:0] prio,
                             int unsigned gap, bit settle);
      stim_item_type it;
      it.word.command        = cmd;
      it.word.entry_tag      = tag;
      it.word.entry_priority = prio;
      it.gap    = gap;
      it.settle = settle;
      stim_items.push_back(it);
      stim_total++;
   endtask

   function automatic logic [2:0] pick_command(mix_type mix);
      int unsigned roll;
      roll = $urandom_range(99);
      case (mix)
         MIX_FILL: begin
            if (roll < 65) return CMD_INSERT;
            if (roll < 75) return CMD_POP;
            if (roll < 88) return CMD_UPGRADE;
            if (roll < 95) return CMD_PEEK;
            if (roll < 97) return CMD_CLEAR;
         end
         MIX_DRAIN: begin
            if (roll < 20) return CMD_INSERT;
            if (roll < 70) return CMD_POP;
            if (roll < 82) return CMD_UPGRADE;
            if (roll < 94) return CMD_PEEK;
            if (roll < 96) return CMD_CLEAR;
         end
         MIX_UPGRADE: begin
            if (roll < 35) return CMD_INSERT;
            if (roll < 45) return CMD_POP;
            if (roll < 90) return CMD_UPGRADE;
            if (roll < 96) return CMD_PEEK;
         end
         default: begin
            if (roll < 40) return CMD_INSERT;
            if (roll < 65) return CMD_POP;
            if (roll < 85) return CMD_UPGRADE;
            if (roll < 92) return CMD_PEEK;
            if (roll < 95) return CMD_CLEAR;
         end
      endcase
      return 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
   endfunction

   // driver: one word in flight on the port, gaps drawn per word
   always @(posedge clock) begin : drive
      rsp_type outcome;
      logic    raise;
      raise = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            outcome = apply_command(req_word);
            step_outcomes.push_back(outcome);
            status_hits[outcome.status]++;
            words_sent++;
         end
         if (!start || !busy) begin
            if (!have_staged && stim_items.size() > 0) begin
               staged      = stim_items.pop_front();
               have_staged = 1'b1;
               gap_left    = staged.gap;
            end
            if (have_staged) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else if (!staged.settle || step_outcomes.size() == 0) begin
                  raise       = 1'b1;
                  req_word    <= staged.word;
                  have_staged = 1'b0;
               end
            end
            start <= raise;
         end
      end
   end

   task automatic compare_field(string label, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t %s: expected %h, got %h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (step_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t reply with nothing outstanding: %h", $time, rsp_word);
         end else begin
            want = step_outcomes.pop_front();
            compare_field("status", want.status, rsp_word.status);
            compare_field("popped_tag", want.popped_tag, rsp_word.popped_tag);
            compare_field("front_tag", want.front_tag, rsp_word.front_tag);
            compare_field("front_priority", want.front_priority, rsp_word.front_priority);
            compare_field("queue_empty", want.queue_empty, rsp_word.queue_empty);
            compare_field("entry_count", want.entry_count, rsp_word.entry_count);
            replies_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      mix_type     mix;
      int          made;
      int          run_len;
      bit          quiet;
      logic [15:0] tag;
      logic [15:0] prio;

      // directed: empty cases, extremes, equal scores, every upgrade outcome
      queue_word(CMD_PEEK, 16'h0000, 16'h0000, 0, 1'b0);
      queue_word(CMD_POP, 16'h0000, 16'h0000, 1, 1'b0);
      queue_word(CMD_UPGRADE, 16'h0003, 16'h0001, 0, 1'b0);
      queue_word(CMD_INSERT, 16'hFFFF, 16'hFFFF, 0, 1'b0);
      queue_word(CMD_INSERT, 16'h0000, 16'h0000, 2, 1'b0);
      queue_word(CMD_INSERT, 16'h0005, 16'hFFFF, 0, 1'b0);
      queue_word(CMD_UPGRADE, 16'h0005, 16'hFFFF, 0, 1'b0);
      queue_word(CMD_UPGRADE, 16'hFFFF, 16'h0000, 3, 1'b0);
      queue_word(CMD_UPGRADE, 16'h0000, 16'h0064, 0, 1'b0);
      queue_word(CMD_UPGRADE, 16'h0007, 16'h0000, 0, 1'b0);
      queue_word(CMD_SPARE_FIRST, 16'hAAAA, 16'h5555, 0, 1'b0);
      queue_word(3'd6, 16'h5555, 16'hAAAA, 9, 1'b0);
      queue_word(CMD_SPARE_LAST, 16'hFFFF, 16'hFFFF, 0, 1'b0);
      queue_word(CMD_PEEK, 16'h0000, 16'h0000, 0, 1'b0);
      queue_word(CMD_POP, 16'h0000, 16'h0000, 0, 1'b0);
      queue_word(CMD_CLEAR, 16'h0000, 16'h0000, 0, 1'b0);
      queue_word(CMD_PEEK, 16'h0000, 16'h0000, 0, 1'b1);

      // random: segments biased toward filling, draining or upgrading, or a general mix;
      // small tag and score pools make hits and ties common
      made = 0;
      while (made < RANDOM_WORDS) begin
         mix     = mix_type'($urandom_range(MIX_ANY, MIX_FILL));
         run_len = $urandom_range(60, 20);
         quiet   = ($urandom_range(3) == 0);
         for (int k = 0; k < run_len; k++) begin
            tag  = ($urandom_range(3) != 0) ? 16'($urandom_range(15))
                                            : 16'($urandom_range(16'hFFFF));
            prio = ($urandom_range(1) == 0) ? 16'($urandom_range(7))
                                            : 16'($urandom_range(16'hFFFF));
            queue_word(pick_command(mix), tag, prio,
                       quiet ? 0 : $urandom_range(9),
                       k == 0 && (made == 0 || $urandom_range(2) == 0));
            made++;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (words_sent == stim_total);
      wait (step_outcomes.size() == 0);
      repeat (8) @(posedge clock);

      $display("%0d commands sent, %0d replies checked, %0d mismatches",
               words_sent, replies_checked, mismatches);
      $display("outcomes: ok %0d, empty %0d, not found %0d, refused %0d, full %0d",
               status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_NOT_FOUND],
               status_hits[ST_REFUSED], status_hits[ST_FULL]);
      if (mismatches == 0 && step_outcomes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
